@@ hdl/fdb_pkg.sv @@
package fdb_pkg;

  // Sample and filter geometry
  localparam int SAMPLE_W = 16;
  localparam int TAPS     = 29;
  localparam int NPAIR    = (TAPS - 1) / 2;   // symmetric tap pairs
  localparam int NDA      = NPAIR + 1;        // pre-added streams incl. centre tap
  localparam int GRP_W    = 5;                // address bits of one lookup table
  localparam int NGRP     = (NDA + GRP_W - 1) / GRP_W;
  localparam int DA_W     = 18;               // one table entry, signed
  localparam int ACC_W    = DA_W + 1;         // partial-product accumulator
  localparam int BIT_W    = 5;                // bit counter, counts 0 .. SAMPLE_W
  localparam int FILL_W   = 5;

  localparam logic [BIT_W-1:0]  LAST_BIT   = BIT_W'(SAMPLE_W);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(TAPS);

  // Q16 coefficients of the first half, centre tap last
  localparam int COEF [NDA] = '{
    -456, -552, 277, 1451, 1229, -646, -1628, 401,
    3007, 1413, -3911, -4983, 4745, 20201, 27808
  };

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic shift;    // take a new sample into the delay line
    logic start;    // clear carries and accumulator
    logic step;     // consume one bit of every sample
    logic msb_sel;  // present the sign bits for the final cycle
  } fdb_ctrl_t;

  // Sum of the coefficients of one group selected by the address bits
  function automatic logic signed [DA_W-1:0] da_entry(input int grp, input int idx);
    int sum;
    int k;
    sum = 0;
    for (int b = 0; b < GRP_W; b++) begin
      k = grp * GRP_W + b;
      if (k < NDA && ((idx >> b) & 1) == 1) begin
        sum = sum + COEF[k];
      end
    end
    return DA_W'(sum);
  endfunction

endpackage

@@ hdl/fdb_delay_line.sv @@
module fdb_delay_line import fdb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdb_ctrl_t           ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [NDA-1:0]      dbits_o
);

  logic [SAMPLE_W-1:0] tap_q [TAPS];
  logic [TAPS-1:0]     bit_w;
  logic [NPAIR-1:0]    carry_q;
  logic [NPAIR-1:0]    carry_d;

  // Shift in a new sample, or rotate every tap by one bit, LSB first
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        tap_q[i] <= tap_q[i+1];
      end
      tap_q[TAPS-1] <= sample_i;
    end else if (ctrl_i.step) begin
      for (int i = 0; i < TAPS; i++) begin
        tap_q[i] <= {tap_q[i][0], tap_q[i][SAMPLE_W-1:1]};
      end
    end
  end

  // Current bit of each tap; after a full rotation the sign bit extends
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      bit_w[i] = ctrl_i.msb_sel ? tap_q[i][SAMPLE_W-1] : tap_q[i][0];
    end
  end

  // Bit-serial pre-adders for the symmetric pairs
  always_comb begin
    for (int j = 0; j < NPAIR; j++) begin
      dbits_o[j] = bit_w[j] ^ bit_w[TAPS-1-j] ^ carry_q[j];
      carry_d[j] = (bit_w[j] & bit_w[TAPS-1-j]) |
                   (bit_w[j] & carry_q[j]) |
                   (bit_w[TAPS-1-j] & carry_q[j]);
    end
    dbits_o[NPAIR] = bit_w[NPAIR];
  end

  // Hold the pre-adder carries between bit cycles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else if (ctrl_i.start) begin
      carry_q <= '0;
    end else if (ctrl_i.step) begin
      carry_q <= carry_d;
    end
  end

endmodule

@@ hdl/fdb_da_acc.sv @@
module fdb_da_acc import fdb_pkg::*; (
  input  logic                clk_i,
  input  fdb_ctrl_t           ctrl_i,
  input  logic [NDA-1:0]      dbits_i,
  output logic [SAMPLE_W-1:0] result_o
);

  logic signed [DA_W-1:0]  tbl_w [NGRP][1 << GRP_W];
  logic signed [ACC_W-1:0] part_w;
  logic signed [ACC_W-1:0] sum_w;
  logic signed [ACC_W-1:0] diff_w;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic [NGRP*GRP_W-1:0]   addr_w;

  // Constant lookup tables of coefficient sums
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar e = 0; e < (1 << GRP_W); e++) begin : g_entry
      assign tbl_w[g][e] = da_entry(g, e);
    end
  end

  // Look up one partial product per group and add them
  always_comb begin
    addr_w = (NGRP*GRP_W)'(dbits_i);
    part_w = '0;
    for (int g = 0; g < NGRP; g++) begin
      part_w = part_w + ACC_W'(tbl_w[g][addr_w[g*GRP_W +: GRP_W]]);
    end
    sum_w  = acc_q + part_w;
    diff_w = acc_q - part_w;
    acc_d  = sum_w >>> 1;
  end

  // Accumulate LSB first, halving each cycle; the sign-bit weight is subtracted
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
  end

  assign result_o = diff_w[SAMPLE_W-1:0];

endmodule

@@ hdl/fir_decimate_by_two.sv @@
// Channel  | Direction | Payload
// s_axis   | in        | tdata[15:0] sample (signed PCM)
// m_axis   | out       | tdata[15:0] filtered_sample (signed)
//
// A sample is taken whenever the block is not computing.
// The 29th sample and every second one after it start a result, computed one bit of
// every tap per cycle through the pre-adders and the lookup-table accumulator.
// A finished result waits in the output register; input is taken meanwhile.
// The last compute cycle holds while the output register is still occupied.
// Reset clears fill count, phase and handshakes; tap contents are not reset.
module fir_decimate_by_two import fdb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata    // [15:0] filtered_sample
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_q, state_d;
  logic [BIT_W-1:0]  cnt_q, cnt_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              phase_q, phase_d;
  logic              out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_data_q;
  logic              in_acc;
  logic              emit;
  logic              load;
  fdb_ctrl_t         ctrl;
  logic [NDA-1:0]    dbits;
  logic [SAMPLE_W-1:0] result;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Sequence fill count, phase and the bit cycles of one result
  always_comb begin
    fill_d      = fill_q;
    phase_d     = phase_q;
    state_d     = state_q;
    cnt_d       = cnt_q;
    emit        = 1'b0;
    load        = 1'b0;
    ctrl        = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.shift = 1'b1;
          if (fill_q != FILL_FULL) begin
            fill_d = fill_q + FILL_W'(1);
          end
          if (fill_d == FILL_FULL) begin
            emit    = !phase_q;
            phase_d = !phase_q;
          end
          if (emit) begin
            ctrl.start = 1'b1;
            state_d    = ST_RUN;
            cnt_d      = '0;
          end
        end
      end
      ST_RUN: begin
        if (cnt_q != LAST_BIT) begin
          ctrl.step = 1'b1;
          cnt_d     = cnt_q + BIT_W'(1);
        end else begin
          ctrl.msb_sel = 1'b1;
          if (!out_valid_q || m_axis_tready) begin
            load        = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the finished result for the output transaction
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= result;
    end
  end

  fdb_delay_line u_delay_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (s_axis_tdata),
    .dbits_o  (dbits)
  );

  fdb_da_acc u_da_acc (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .dbits_i  (dbits),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Bit counter never passes the sign-bit cycle
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_BIT)
    else $error("bit counter out of range");

  // Phase only toggles once the delay line is full
  a_phase_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != $past(phase_q)) |-> (fill_q == FILL_FULL))
    else $error("phase toggled before delay line full");

  // A new result comes only from the last compute cycle
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_RUN && cnt_q == LAST_BIT))
    else $error("result presented without a finished computation");

  // Compute never starts before the delay line is full
  a_run_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (fill_q == FILL_FULL))
    else $error("computation with partly filled delay line");

endmodule
